FILE: hdl/dbs_pkg.sv
// Package for the bounded deque with search.
// Holds the request, status and sequencer state codes and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package dbs_pkg;

    localparam int ITEM_W  = 32;
    localparam int REQ_W   = 3;
    localparam int TOTAL_W = 6;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 80;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FRONT = 3'd0,
        REQ_ADD_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_BACK  = 3'd3,
        REQ_CONTAINS  = 3'd4,
        REQ_REM_VAL   = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT_RD,
        S_BACK_RD,
        S_BACK_CAP,
        S_DONE
    } t_state;

endpackage

FILE: hdl/dbs_mem.sv
// Entry store of the deque: one write port, one read port, registered read data.
// Standalone; sized by its parameters.
`timescale 1ns / 1ps

module dbs_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: request sequencer and output register.
// Depends on dbs_pkg and dbs_mem.
//
//  channel   dir  beat fields (lsb first)
//  s_axis    in   tuser: req_type[2:0]; tdata: item_value[31:0]
//  m_axis    out  tdata: front_value, back_value, is_empty, entry_total, value_found,
//                 status, zero pad to 80 bits
//
// An add, a front or back removal or an unused code runs the execute state, then the
// front read, back read and back capture states (only front read if the deque is empty
// afterwards), then waits in done until the output is free, loads the result beat and
// returns to idle, where the next beat is accepted. Contains and remove value scan first:
// a read and a compare state per entry compared, and one more step if nothing matches;
// remove value with a match adds a read and a write state per entry moved up and a
// closing step. Each entry visit and the front and back reads use the single read port.
// Reset clears the front position, the count and the output valid; the store is not cleared.
// A new beat is accepted while a result waits; the next result holds until it is taken.
`timescale 1ns / 1ps

module bounded_deque_with_search #(
    parameter int CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dbs_pkg::ITEM_W-1:0]    s_axis_tdata,   // item_value[31:0]
    input  logic [dbs_pkg::REQ_W-1:0]     s_axis_tuser,   // req_type[2:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // front_value[31:0], back_value[63:32], is_empty[64], entry_total[70:65],
    // value_found[71], status[73:72], zero[79:74]
    output logic [dbs_pkg::OUT_W-1:0]     m_axis_tdata
);

    import dbs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_fp, n_fp;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_idx, n_idx;
    t_req                  r_req;
    logic [ITEM_W-1:0]     r_val;
    logic                  r_found, n_found;
    t_status               r_status, n_status;
    logic [ITEM_W-1:0]     r_front, n_front;
    logic [ITEM_W-1:0]     r_back, n_back;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_W-1:0]      r_out, n_out;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_out_free;
    logic                  w_match;
    logic                  w_shift_end;
    logic [CW-1:0]         w_log;
    logic [CW:0]           w_sum;
    logic [AW-1:0]         w_slot;
    logic [AW-1:0]         w_fp_dec;
    logic [AW-1:0]         w_fp_inc;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [ITEM_W-1:0]     w_wr_data;
    logic                  w_rd_en;
    logic [ITEM_W-1:0]     w_rd_data;
    logic [TOTAL_W-1:0]    w_total;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign w_full      = (r_cnt == CW'(CAPACITY));
    assign w_empty     = (r_cnt == '0);
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_match     = (w_rd_data == r_val);
    assign w_shift_end = ((r_idx + 1'b1) == r_cnt);
    assign w_total     = TOTAL_W'(r_cnt);

    assign w_fp_dec = (r_fp == '0) ? AW'(CAPACITY - 1) : (r_fp - 1'b1);
    assign w_fp_inc = (r_fp == AW'(CAPACITY - 1)) ? '0 : (r_fp + 1'b1);

    always_comb begin
        unique case (r_state)
            S_EXEC:     w_log = r_cnt;
            S_SHIFT_RD: w_log = r_idx + 1'b1;
            S_BACK_RD:  w_log = r_cnt - 1'b1;
            S_FRONT_RD: w_log = '0;
            default:    w_log = r_idx;
        endcase
    end

    always_comb begin
        w_sum = (CW+1)'(r_fp) + (CW+1)'(w_log);
        if (w_sum >= (CW+1)'(CAPACITY)) begin
            w_sum = w_sum - (CW+1)'(CAPACITY);
        end
    end

    assign w_slot = AW'(w_sum);

    dbs_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (ITEM_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_slot),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_req) inside
                    REQ_CONTAINS, REQ_REM_VAL: n_state = S_SCAN_RD;
                    default:                   n_state = S_FRONT_RD;
                endcase
            end
            S_SCAN_RD: begin
                n_state = (r_idx == r_cnt) ? S_FRONT_RD : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (!w_match) begin
                    n_state = S_SCAN_RD;
                end else if (r_req == REQ_REM_VAL) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_FRONT_RD;
                end
            end
            S_SHIFT_RD: begin
                n_state = w_shift_end ? S_FRONT_RD : S_SHIFT_WR;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_FRONT_RD: begin
                n_state = w_empty ? S_DONE : S_BACK_RD;
            end
            S_BACK_RD:  n_state = S_BACK_CAP;
            S_BACK_CAP: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and store accesses
    always_comb begin
        n_fp        = r_fp;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_found     = r_found;
        n_status    = r_status;
        n_front     = r_front;
        n_back      = r_back;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_slot;
        w_wr_data   = r_val;
        w_rd_en     = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_found  = 1'b0;
                n_status = STAT_OK;
                n_idx    = '0;
            end
            S_EXEC: begin
                unique case (r_req) inside
                    REQ_ADD_FRONT: begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_fp_dec;
                            n_fp      = w_fp_dec;
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    REQ_ADD_BACK: begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end
                    end
                    REQ_REM_FRONT: begin
                        if (w_empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_fp  = w_fp_inc;
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    REQ_REM_BACK: begin
                        if (w_empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    REQ_CONTAINS, REQ_REM_VAL: begin
                        n_status = STAT_NOT_FOUND;
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
            S_SCAN_RD: begin
                w_rd_en = (r_idx != r_cnt);
            end
            S_SCAN_CMP: begin
                if (w_match) begin
                    n_found  = 1'b1;
                    n_status = STAT_OK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT_RD: begin
                if (w_shift_end) begin
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            S_SHIFT_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_rd_data;
                n_idx     = r_idx + 1'b1;
            end
            S_FRONT_RD: begin
                if (w_empty) begin
                    n_front = '0;
                    n_back  = '0;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            S_BACK_RD: begin
                n_front = w_rd_data;
                w_rd_en = 1'b1;
            end
            S_BACK_CAP: begin
                n_back = w_rd_data;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = {6'd0, r_status, r_found, w_total, w_empty, r_back, r_front};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fp        <= n_fp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(s_axis_tuser);
            r_val <= s_axis_tdata;
        end
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_front  <= n_front;
        r_back   <= n_back;
        r_out    <= n_out;
    end

endmodule

FILE: hdl/dbs_chk.sv
// Port checker for the bounded deque with search, bound to the top level.
// Depends on dbs_pkg; watches only the top level's ports.
`timescale 1ns / 1ps

module dbs_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [dbs_pkg::ITEM_W-1:0]    s_axis_tdata,
    input  logic [dbs_pkg::REQ_W-1:0]     s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [dbs_pkg::OUT_W-1:0]     m_axis_tdata
);

    import dbs_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // drop ready for the cycle after an accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |->
            m_axis_tdata[31:0] == '0 && m_axis_tdata[63:32] == '0 &&
            m_axis_tdata[70:65] == '0)
        else $error("empty result with nonzero front, back or count");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[73:72] == STAT_OK)
        else $error("found flag with failing status");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:74] == '0)
        else $error("nonzero pad bits");

endmodule

bind bounded_deque_with_search dbs_chk u_dbs_chk (.*);
